// ===== rtl/best_fit_region_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Best-fit region allocator assertion macros
// Shared property wrappers clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_REGION_ALLOCATOR_DEFINES_SVH

// Plain clocked check that holds on every edge outside reset.
`define BFRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: when the antecedent holds, the consequent follows next cycle.
`define BFRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfra_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit region allocator package
// Shared widths, codes, table entry type and helper functions.
// ----------------------------------------------------------------------------
package bfra_pkg;

  localparam int MAX_REGIONS = 32;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_NOFIT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] age;
  } entry_t;

  // Lowest set bit of a slot mask; the top bit of the result flags a hit.
  function automatic logic [IDX_W:0] first_set(input logic [MAX_REGIONS-1:0] v);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, IDX_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/bfra_in_if.sv =====
// ----------------------------------------------------------------------------
// Best-fit region allocator request channel
// Valid/ready channel carrying one allocate, free or restart request.
// ----------------------------------------------------------------------------
interface bfra_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] req_bytes;
  logic [31:0] free_offset;

  modport source (output valid, action, req_bytes, free_offset, input ready);
  modport sink   (input valid, action, req_bytes, free_offset, output ready);
endinterface

// ===== rtl/bfra_out_if.sv =====
// ----------------------------------------------------------------------------
// Best-fit region allocator result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface bfra_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_offset;
  logic [31:0] bytes_in_use;

  modport source (output valid, status, alloc_offset, bytes_in_use, input ready);
  modport sink   (input valid, status, alloc_offset, bytes_in_use, output ready);
endinterface

// ===== rtl/best_fit_region_allocator.sv =====
// Allocate and free go from S_IDLE through the scan state S_SCAN to S_FIN and the result;
// restart and no-op go from S_IDLE straight to S_FIN. One request is worked on at a time.
// Throughput is set by the scan of the region memory, one entry read per cycle.
// Reset (rst_n low, synchronous) empties the table, clears the byte total, the
// age counter and pool_r. The region memory itself is not cleared.
// ----------------------------------------------------------------------------
// Best-fit region allocator
// Keeps free regions of a byte pool in a memory and serves best-fit allocates,
// coalescing frees and pool restarts.
// ----------------------------------------------------------------------------
`include "best_fit_region_allocator_defines.svh"

module best_fit_region_allocator
  import bfra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bfra_in_if.sink     in_ch,
  bfra_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  entry_t mem [MAX_REGIONS];
  entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [DATA_W-1:0] pool_r;
  logic [MAX_REGIONS-1:0] valid_r, valid_nxt;
  logic [DATA_W-1:0] ins_r, ins_nxt;
  logic [DATA_W-1:0] total_r, total_nxt;

  op_t               op_r;
  logic [DATA_W-1:0] req_r, foff_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]  rd_idx_r;

  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [DATA_W-1:0] best_size_r, best_size_nxt;
  logic [DATA_W-1:0] best_age_r, best_age_nxt;
  logic [DATA_W-1:0] best_start_r, best_start_nxt;

  logic [MAX_REGIONS-1:0] merged_r, merged_nxt;
  logic [DATA_W-1:0] mstart_r, mstart_nxt;
  logic [DATA_W:0]   msum_r, msum_nxt;

  logic              out_valid_r;
  status_t           out_status_r, status_nxt;
  logic [DATA_W-1:0] out_off_r, off_nxt;
  logic [DATA_W-1:0] out_total_r;

  logic              out_ok, accept, entry_ok;
  logic [DATA_W:0]   alloc_sum, free_end, left_end, msum_add;
  logic [IDX_W:0]    free_slot, merge_slot;
  logic [IDX_W-1:0]  slot;

  assign out_ok   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;

  assign alloc_sum = {1'b0, total_r} + {1'b0, req_r};
  assign free_end  = {1'b0, foff_r} + {1'b0, req_r};
  assign left_end  = {1'b0, rd_data_r.start} + {1'b0, rd_data_r.size};
  assign msum_add  = msum_r + {1'b0, rd_data_r.size};
  assign entry_ok  = rd_pend_r && valid_r[rd_idx_r];
  assign free_slot  = first_set(~valid_r);
  assign merge_slot = first_set(merged_r);
  assign slot = (merged_r != '0) ? merge_slot[IDX_W-1:0] : free_slot[IDX_W-1:0];
  assign rd_addr = cnt_r[IDX_W-1:0];

  // Region memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_pend_nxt    = 1'b0;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_size_nxt  = best_size_r;
    best_age_nxt   = best_age_r;
    best_start_nxt = best_start_r;
    merged_nxt     = merged_r;
    mstart_nxt     = mstart_r;
    msum_nxt       = msum_r;
    valid_nxt      = valid_r;
    ins_nxt        = ins_r;
    total_nxt      = total_r;
    status_nxt     = ST_OK;
    off_nxt        = '0;
    we             = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          merged_nxt = '0;
          mstart_nxt = in_ch.free_offset;
          msum_nxt   = {1'b0, in_ch.req_bytes};
          if (op_t'(in_ch.action) == OP_ALLOC || op_t'(in_ch.action) == OP_FREE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r != CNT_W'(MAX_REGIONS)) begin
          rd_pend_nxt = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
        end else if (!rd_pend_r) begin
          state_nxt = S_FIN;
        end
        if (entry_ok) begin
          if (op_r == OP_ALLOC) begin
            if (rd_data_r.size >= req_r &&
                (!found_r || rd_data_r.size < best_size_r ||
                 (rd_data_r.size == best_size_r && rd_data_r.age < best_age_r))) begin
              found_nxt      = 1'b1;
              best_idx_nxt   = rd_idx_r;
              best_size_nxt  = rd_data_r.size;
              best_age_nxt   = rd_data_r.age;
              best_start_nxt = rd_data_r.start;
            end
          end else if ({1'b0, rd_data_r.start} == free_end || left_end == {1'b0, foff_r}) begin
            merged_nxt[rd_idx_r] = 1'b1;
            // Sticky saturation: once past 32 bits the sum stays at 2^32.
            msum_nxt = msum_add[DATA_W] ? {1'b1, {DATA_W{1'b0}}} : msum_add;
            if ({1'b0, rd_data_r.start} != free_end) begin
              mstart_nxt = rd_data_r.start;
            end
          end
        end
      end
      S_FIN: begin
        if (out_ok) begin
          state_nxt = S_IDLE;
          unique case (op_r)
            OP_ALLOC: begin
              if (alloc_sum > {1'b0, pool_r}) begin
                status_nxt = ST_OVER;
              end else if (!found_r) begin
                status_nxt = ST_NOFIT;
              end else begin
                off_nxt   = best_start_r;
                total_nxt = alloc_sum[DATA_W-1:0];
                if (best_size_r > req_r) begin
                  we      = 1'b1;
                  wr_addr = best_idx_r;
                  wr_data = '{start: best_start_r + req_r,
                              size:  best_size_r - req_r,
                              age:   ins_r};
                  ins_nxt = ins_r + 1'b1;
                end else begin
                  valid_nxt[best_idx_r] = 1'b0;
                end
              end
            end
            OP_FREE: begin
              if (merged_r == '0 && !free_slot[IDX_W]) begin
                status_nxt = ST_FULL;
              end else begin
                valid_nxt       = valid_r & ~merged_r;
                valid_nxt[slot] = 1'b1;
                we      = 1'b1;
                wr_addr = slot;
                wr_data = '{start: mstart_r,
                            size:  msum_r[DATA_W] ? {DATA_W{1'b1}} : msum_r[DATA_W-1:0],
                            age:   ins_r};
                ins_nxt   = ins_r + 1'b1;
                total_nxt = (total_r >= req_r) ? total_r - req_r : '0;
              end
            end
            OP_RESTART: begin
              valid_nxt    = '0;
              valid_nxt[0] = 1'b1;
              we        = 1'b1;
              wr_addr   = '0;
              wr_data   = '{start: '0, size: pool_r, age: '0};
              ins_nxt   = DATA_W'(1);
              total_nxt = '0;
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      ins_r       <= '0;
      total_r     <= '0;
      pool_r      <= '0;
      rd_pend_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      ins_r     <= ins_nxt;
      total_r   <= total_nxt;
      rd_pend_r <= rd_pend_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_we) begin
        pool_r <= cfg_wdata;
      end
      if (state_r == S_FIN && out_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_addr;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_size_r  <= best_size_nxt;
    best_age_r   <= best_age_nxt;
    best_start_r <= best_start_nxt;
    merged_r     <= merged_nxt;
    mstart_r     <= mstart_nxt;
    msum_r       <= msum_nxt;
    if (accept) begin
      op_r   <= op_t'(in_ch.action);
      req_r  <= in_ch.req_bytes;
      foff_r <= in_ch.free_offset;
    end
    if (state_r == S_FIN && out_ok) begin
      out_status_r <= status_nxt;
      out_off_r    <= off_nxt;
      out_total_r  <= total_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.alloc_offset = out_off_r;
  assign out_ch.bytes_in_use = out_total_r;

  `BFRA_ASSERT(a_cnt_range, cnt_r <= CNT_W'(MAX_REGIONS), "scan counter out of range")
  `BFRA_ASSERT(a_grant_valid,
    !(state_r == S_FIN && op_r == OP_ALLOC && found_r) || valid_r[best_idx_r],
    "best-fit slot is not a valid region")
  `BFRA_ASSERT_NEXT(a_restart_seed, state_r == S_FIN && op_r == OP_RESTART && out_ok,
    valid_r == MAX_REGIONS'(1), "restart did not leave a single seeded region")
  `BFRA_ASSERT_NEXT(a_no_read_outside_scan, state_r != S_SCAN, !rd_pend_r,
    "memory read pending outside the scan")

endmodule

// ===== sim/best_fit_region_allocator_test.sv =====
// ----------------------------------------------------------------------------
// Best-fit region allocator testbench
// Drives allocate, free, restart and no-op requests with random gaps and stalls,
// predicts each result from a private copy of the region table, and checks
// every result against the oldest prediction.
// ----------------------------------------------------------------------------
module best_fit_region_allocator_test;
  import bfra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_offset;
    logic [31:0] bytes_in_use;
  } outcome_t;

  class region_scoreboard;
    logic [31:0] pool_bytes;
    logic [31:0] sz [MAX_REGIONS];
    logic [31:0] st [MAX_REGIONS];
    logic [31:0] ag [MAX_REGIONS];
    bit          vld [MAX_REGIONS];
    logic [31:0] age_ctr;
    logic [31:0] in_use;
    outcome_t    pending[$];
    int          errors;

    function void clear();
      foreach (vld[i]) vld[i] = 0;
      pool_bytes = '0;
      age_ctr = '0;
      in_use = '0;
      pending.delete();
      errors = 0;
    endfunction

    function logic [31:0] take_age();
      take_age = age_ctr;
      age_ctr = age_ctr + 1;
    endfunction

    function outcome_t grant(logic [31:0] req);
      outcome_t r;
      int best;
      logic [32:0] sum;
      r = '0;
      best = -1;
      sum = {1'b0, in_use} + req;
      if (sum > {1'b0, pool_bytes}) begin
        r.status = ST_OVER;
        return r;
      end
      for (int i = 0; i < MAX_REGIONS; i++) begin
        if (vld[i] && sz[i] >= req) begin
          if (best < 0 || sz[i] < sz[best] || (sz[i] == sz[best] && ag[i] < ag[best]))
            best = i;
        end
      end
      if (best < 0) begin
        r.status = ST_NOFIT;
        return r;
      end
      r.alloc_offset = st[best];
      if (sz[best] > req) begin
        sz[best] = sz[best] - req;
        st[best] = st[best] + req;
        ag[best] = take_age();
      end else begin
        vld[best] = 0;
      end
      in_use = sum[31:0];
      r.status = ST_OK;
      return r;
    endfunction

    function logic [1:0] release_range(logic [31:0] base, logic [31:0] req);
      logic [32:0] end_addr;
      logic [33:0] total;
      logic [31:0] new_start;
      bit hit [MAX_REGIONS];
      bit any;
      int slot;
      end_addr = {1'b0, base} + req;
      total = {2'b0, req};
      new_start = base;
      any = 0;
      slot = -1;
      for (int i = 0; i < MAX_REGIONS; i++) begin
        hit[i] = 0;
        if (vld[i]) begin
          if ({1'b0, st[i]} == end_addr) hit[i] = 1;
          else if ({1'b0, st[i]} + sz[i] == {1'b0, base}) begin
            hit[i] = 1;
            new_start = st[i];
          end
          if (hit[i]) begin
            any = 1;
            total = total + sz[i];
          end
        end
      end
      if (!any) begin
        for (int i = 0; i < MAX_REGIONS; i++)
          if (!vld[i] && slot < 0) slot = i;
        if (slot < 0) return ST_FULL;
      end
      for (int i = 0; i < MAX_REGIONS; i++) begin
        if (hit[i]) begin
          vld[i] = 0;
          if (slot < 0) slot = i;
        end
      end
      if (total > 34'hFFFF_FFFF) total = 34'hFFFF_FFFF;
      vld[slot] = 1;
      st[slot] = new_start;
      sz[slot] = total[31:0];
      ag[slot] = take_age();
      in_use = (in_use >= req) ? in_use - req : '0;
      return ST_OK;
    endfunction

    function void note_request(logic [1:0] act, logic [31:0] req, logic [31:0] off);
      outcome_t r;
      r = '0;
      case (act)
        OP_ALLOC: r = grant(req);
        OP_FREE: r.status = release_range(off, req);
        OP_RESTART: begin
          foreach (vld[i]) vld[i] = 0;
          age_ctr = '0;
          vld[0] = 1;
          st[0] = '0;
          sz[0] = pool_bytes;
          ag[0] = take_age();
          in_use = '0;
        end
        default: ;
      endcase
      r.bytes_in_use = in_use;
      pending.push_back(r);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d off=%h used=%h", $time,
                 got.status, got.alloc_offset, got.bytes_in_use);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.alloc_offset != want.alloc_offset) begin
        $display("%0t: alloc_offset expected %h actual %h", $time,
                 want.alloc_offset, got.alloc_offset);
        errors++;
      end
      if (got.bytes_in_use != want.bytes_in_use) begin
        $display("%0t: bytes_in_use expected %h actual %h", $time,
                 want.bytes_in_use, got.bytes_in_use);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  bfra_in_if   in_ch();
  bfra_out_if  out_ch();

  best_fit_region_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  region_scoreboard board;
  int unsigned cycle_count;
  bit          hold_off;
  logic [31:0] live_off [$];
  logic [31:0] live_len [$];

  initial clk = 0;
  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.action = OP_NOP;
    in_ch.req_bytes = '0;
    in_ch.free_offset = '0;
    out_ch.ready = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    rst_n = 0;
    hold_off = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** best_fit_region_allocator: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off when asked.
  // Ready stays high across a transfer when the next wait is zero.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap != 0 || hold_off) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      board.check_result({out_ch.status, out_ch.alloc_offset, out_ch.bytes_in_use});
    end
  end

  task automatic send(logic [1:0] act, logic [31:0] req, logic [31:0] off, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    repeat (gap) @(posedge clk);
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.req_bytes <= req;
    in_ch.free_offset <= off;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(act, req, off);
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_pool(logic [31:0] bytes);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= bytes;
    @(posedge clk);
    board.pool_bytes = bytes;
    cfg_we <= 0;
  endtask

  // Mostly well-formed traffic: allocate, remember grants, free them back in random order.
  task automatic random_op(logic [31:0] scale);
    int k;
    int pick;
    logic [31:0] req;
    bit quick;
    quick = ($urandom_range(0, 9) < 2);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      req = $urandom_range(0, scale);
      send(OP_ALLOC, req, $urandom, quick);
      if (board.pending[$].status == ST_OK && req != 0) begin
        live_off.push_back(board.pending[$].alloc_offset);
        live_len.push_back(req);
      end
    end else if (pick < 85 && live_off.size() > 0) begin
      k = $urandom_range(0, live_off.size() - 1);
      send(OP_FREE, live_len[k], live_off[k], quick);
      if (board.pending[$].status == ST_OK) begin
        live_off.delete(k);
        live_len.delete(k);
      end
    end else if (pick < 93) begin
      send(OP_FREE, $urandom_range(1, scale), $urandom_range(0, 4 * scale), quick);
    end else if (pick < 96) begin
      send(OP_ALLOC, $urandom, $urandom, quick);
    end else if (pick < 98) begin
      send(OP_NOP, $urandom, $urandom, quick);
    end else begin
      send(OP_RESTART, $urandom, $urandom, quick);
      live_off.delete();
      live_len.delete();
    end
  endtask

  initial begin
    logic [31:0] pools [5];
    board = new();
    board.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part.
    send(OP_ALLOC, 0, 0, 0);
    send(OP_FREE, 32'd16, 32'd100, 0);
    send(OP_RESTART, 0, 0, 0);
    send(OP_ALLOC, 0, 0, 0);
    set_pool(32'd1000);
    send(OP_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send(OP_ALLOC, 32'd1001, 0, 0);
    send(OP_ALLOC, 32'd100, 0, 0);
    send(OP_ALLOC, 32'd200, 0, 0);
    send(OP_ALLOC, 32'd0, 0, 0);
    send(OP_FREE, 32'd100, 32'd0, 0);
    send(OP_ALLOC, 32'd50, 0, 0);
    send(OP_ALLOC, 32'd800, 0, 0);
    send(OP_FREE, 32'd200, 32'd100, 0);
    send(OP_FREE, 32'd900, 32'd50, 0);
    send(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    set_pool(32'hFFFF_FFFF);
    send(OP_RESTART, 0, 0, 0);
    send(OP_ALLOC, 32'hFFFF_FFFF, 0, 0);
    send(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send(OP_FREE, 32'h10, 32'hFFFF_FFF0, 0);
    set_pool(32'd4);
    send(OP_ALLOC, 32'd1, 0, 0);
    // Table full: scattered one-byte frees that never touch each other.
    set_pool(32'd0);
    send(OP_RESTART, 0, 0, 0);
    for (int i = 0; i < 33; i++) send(OP_FREE, 32'd1, 32'd10 + 3 * i, 1);

    // Long hold-off on results while requests keep coming.
    set_pool(32'd4096);
    send(OP_RESTART, 0, 0, 0);
    hold_off = 1;
    fork
      begin
        for (int i = 0; i < 12; i++) random_op(32'd300);
      end
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
    join

    pools = '{32'd0, 32'd64, 32'd4096, 32'd100000, 32'hFFFF_FFFF};
    for (int ph = 0; ph < 5; ph++) begin
      set_pool(pools[ph]);
      send(OP_RESTART, 0, 0, 0);
      live_off.delete();
      live_len.delete();
      for (int i = 0; i < 100; i++)
        random_op(pools[ph] == 0 ? 32'd8 :
                  (pools[ph] > 32'd100000 ? 32'hFFFF : pools[ph] / 6 + 1));
      // Lower the limit under the live total so allocations fail as over-limit.
      if (ph == 2) begin
        set_pool(32'd10);
        for (int i = 0; i < 6; i++) random_op(32'd300);
      end
    end

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) $display("** best_fit_region_allocator: PASSED **");
    else $display("** best_fit_region_allocator: FAILED **");
    $finish;
  end
endmodule
